// ----- hdl/kms_pkg.sv -----
// Shared types and constants for the k-mismatch string search block.
package kms_pkg;

  // Mismatch counter width and its saturation value
  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CFG_W = 7;

  // Percent handling: floor(x / 100) == (x * 5243) >> 19 for x < 2^15
  localparam logic [CFG_W-1:0] PERCENT_FULL = 7'd100;
  localparam int unsigned RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // Input commands (tuser)
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Register index (paddr word address)
  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_MATCH_PERCENT  = 1'b1;

  // Broadcast to every cell for one accepted word
  typedef struct packed {
    logic             text;
    logic             restart;
    logic [SYM_W-1:0] symbol;
  } kms_step_t;

endpackage

// ----- hdl/k_mismatch_string_search.sv -----
// Top level of the k-mismatch string search: cell chain, result select, APB registers.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser: command; tdata: pattern_index, symbol
//  m_axis    out  tvalid/tready             tdata: match_start, mismatch_count
//  apb       in   psel/penable, pready=1    pattern_length @0x0, match_percent @0x4
//
// Each accepted text word updates all cells at once; the matching alignment is then
// picked out of the chain and compared to the limit in the select stage, and a hit is
// registered into the output. Sustained rate is one word per cycle, set by the
// cell chain; a stalled m_axis holds the select stage and with it s_axis_tready.
// A register write locks out s_axis while the limit multiply settles.
// Reset clears the counters and the position and sets the registers to length 1 and
// 100 percent; pattern bytes are undefined until loaded.
module k_mismatch_string_search #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned MAX_TEXT    = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] pattern_index, [13:6] symbol, zero fill
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] match_start, [22:16] mismatch_count, zero fill
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kms_pkg::*;

  localparam int unsigned LW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PW   = $clog2(MAX_TEXT);
  localparam int unsigned CMPW = (PW > LW) ? PW : LW;
  localparam int unsigned PRW  = LW + CFG_W;
  localparam int unsigned QW   = PRW + RECIP_W;
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_TEXT - 1);

  // ---------------- registers ----------------
  logic [CFG_W-1:0] plen_q, pct_q;
  logic [1:0]       wait_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= CFG_W'(1);
      pct_q  <= PERCENT_FULL;
      wait_q <= '0;
    end else begin
      if (cfg_wr) begin
        wait_q <= 2'd2;
        case (paddr[2])
          REG_PATTERN_LENGTH: plen_q <= pwdata[CFG_W-1:0];
          REG_MATCH_PERCENT:  pct_q  <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end else if (wait_q != 2'd0) begin
        wait_q <= wait_q - 2'd1;
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PATTERN_LENGTH: prdata = 32'(plen_q);
      REG_MATCH_PERCENT:  prdata = 32'(pct_q);
      default:            prdata = '0;
    endcase
  end

  // effective length and percent (clamped)
  logic [LW-1:0]    len_eff, len_m1;
  logic [CFG_W-1:0] pct_eff;

  always_comb begin
    if (plen_q == '0) begin
      len_eff = LW'(1);
    end else if (9'(plen_q) > 9'(MAX_PATTERN)) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(plen_q);
    end
    pct_eff = (pct_q > PERCENT_FULL) ? PERCENT_FULL : pct_q;
  end

  assign len_m1 = len_eff - LW'(1);

  // limit = max(1, L - floor(L*pct/100)), two register stages
  logic [PRW-1:0] prod_q;
  logic [QW-1:0]  quot_full;
  logic [LW-1:0]  quot, lim_raw, limit_q;

  assign quot_full = QW'(prod_q) * QW'(RECIP_100);
  assign quot      = LW'(quot_full >> RECIP_SHIFT);
  assign lim_raw   = len_eff - quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q  <= PRW'(PERCENT_FULL);
      limit_q <= LW'(1);
    end else begin
      prod_q  <= PRW'(len_eff) * PRW'(pct_eff);
      limit_q <= (lim_raw == '0) ? LW'(1) : lim_raw;
    end
  end

  // ---------------- input side ----------------
  logic            in_acc;
  logic [1:0]      cmd;
  logic [IDX_W-1:0] idx;
  kms_step_t       step;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cmd    = s_axis_tuser;
  assign idx    = s_axis_tdata[IDX_W-1:0];

  assign step.text    = in_acc && (cmd == CMD_TEXT);
  assign step.restart = in_acc && (cmd == CMD_RESTART);
  assign step.symbol  = s_axis_tdata[IDX_W +: SYM_W];

  // ---------------- cell chain ----------------
  logic [CNT_W-1:0] cnt [MAX_PATTERN];

  for (genvar d = 0; d < MAX_PATTERN; d++) begin : g_cell
    localparam logic [8:0] SLOT = 9'(d);
    logic             load;
    logic [CNT_W-1:0] prev;

    assign load = in_acc && (cmd == CMD_LOAD) && (9'(idx) == SLOT);
    if (d == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = cnt[d-1];
    end

    kms_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .load_i (load),
      .cnt_i  (prev),
      .cnt_o  (cnt[d])
    );
  end

  // ---------------- text position ----------------
  logic [PW-1:0] pos_q, pend_pos_q;
  logic          pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (step.restart) begin
      pos_q <= '0;
    end else if (step.text && (pos_q != POS_LAST)) begin
      pos_q <= pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.text) begin
      pend_pos_q <= pos_q;
    end
  end

  // ---------------- select stage ----------------
  logic [CNT_W-1:0] sel_cnt;
  logic             hit, out_free, pend_go;
  logic [CMPW-1:0]  start;

  assign sel_cnt  = cnt[len_m1[IW-1:0]];
  assign hit      = pend_q && (CMPW'(pend_pos_q) >= CMPW'(len_m1))
                    && (9'(sel_cnt) < 9'(limit_q));
  assign start    = CMPW'(pend_pos_q) - CMPW'(len_m1);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign pend_go  = pend_q && (!hit || out_free);

  assign s_axis_tready = (wait_q == 2'd0) && (!pend_q || pend_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (in_acc) begin
      pend_q <= (cmd == CMD_TEXT);
    end else if (pend_go) begin
      pend_q <= 1'b0;
    end
  end

  // ---------------- output register ----------------
  logic [23:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (pend_go && hit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_go && hit) begin
      out_data_q <= {1'b0, sel_cnt, 16'(start)};
    end
  end

  assign m_axis_tdata = out_data_q;

  // ---------------- checks ----------------
  a_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_q != 2'd0) |-> !s_axis_tready)
    else $error("input taken while limit settles");

  a_text_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.text |=> pend_q)
    else $error("text word lost before select stage");

  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.restart |=> (pos_q == '0))
    else $error("restart did not clear position");

  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_go && hit) |=> (9'(m_axis_tdata[22:16]) < 9'(limit_q)))
    else $error("reported count not below limit");

endmodule

// ----- hdl/kms_cell.sv -----
// One alignment cell: a pattern byte and the mismatch count handed down the chain.
module kms_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kms_pkg::kms_step_t       step_i,
  input  logic                     load_i,
  input  logic [kms_pkg::CNT_W-1:0] cnt_i,
  output logic [kms_pkg::CNT_W-1:0] cnt_o
);
  import kms_pkg::*;

  logic [SYM_W-1:0] pattern_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             miss;

  // pattern byte: payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pattern_q <= step_i.symbol;
    end
  end

  assign miss = (pattern_q != step_i.symbol);

  always_comb begin
    cnt_d = cnt_q;
    if (step_i.restart) begin
      cnt_d = '0;
    end else if (step_i.text) begin
      cnt_d = (miss && (cnt_i != CNT_MAX)) ? cnt_i + CNT_W'(1) : cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ----- tb/sv/kms_match_checker.sv -----
// Scoreboard for the k-mismatch search: tracks registers, predicts hits, compares results.
`timescale 1ns / 100ps

module kms_match_checker
  import kms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] pattern_index, [13:6] symbol, zero fill
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [15:0] match_start, [22:16] mismatch_count, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned hits_pending_o,
  output int unsigned fail_count_o
);

  localparam int unsigned PAT_DEPTH = 64;
  localparam int unsigned POS_LAST  = 65535;
  localparam int unsigned LOG_CAP   = 64;

  typedef struct packed {
    logic [15:0]      start;
    logic [CNT_W-1:0] mism;
  } hit_t;

  logic [SYM_W-1:0] pat_mem   [PAT_DEPTH] = '{default: '0};
  logic [CNT_W-1:0] align_cnt [PAT_DEPTH] = '{default: '0};
  int unsigned      text_pos = 0;
  logic [CFG_W-1:0] len_reg  = 7'd1;
  logic [CFG_W-1:0] pct_reg  = PERCENT_FULL;
  hit_t             hit_q [$];
  int unsigned      fails    = 0;

  // Log is capped so a broken block cannot flood the output; every miss is counted.
  task report(input string msg);
    if (fails < LOG_CAP) $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  function automatic int unsigned span_of(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > PAT_DEPTH) return PAT_DEPTH;
    return raw;
  endfunction

  // Fewest mismatches that rejects an alignment; never below one.
  function automatic int unsigned reject_at(input int unsigned span);
    int unsigned pct;
    int unsigned lim;
    pct = (pct_reg > PERCENT_FULL) ? PERCENT_FULL : pct_reg;
    lim = span - (span * pct) / PERCENT_FULL;
    return (lim < 1) ? 1 : lim;
  endfunction

  // One text byte: every alignment shifts one cell deeper and picks up its compare.
  task automatic shift_text(input logic [SYM_W-1:0] sym);
    int unsigned span;
    logic [CNT_W-1:0] c;
    hit_t h;
    span = span_of(len_reg);
    for (int d = PAT_DEPTH - 1; d >= 1; d--) begin
      c = align_cnt[d-1];
      if (pat_mem[d] != sym && c < CNT_MAX) c = c + 1'b1;
      align_cnt[d] = c;
    end
    align_cnt[0] = (pat_mem[0] != sym) ? 7'd1 : 7'd0;
    if (text_pos >= span - 1) begin
      c = align_cnt[span-1];
      if (c < reject_at(span)) begin
        h.start = 16'(text_pos - (span - 1));
        h.mism  = c;
        hit_q.push_back(h);
      end
    end
    if (text_pos < POS_LAST) text_pos++;
  endtask

  task automatic take_word(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [SYM_W-1:0] sym);
    case (cmd)
      CMD_LOAD: begin
        if (idx < PAT_DEPTH) pat_mem[idx] = sym;
      end
      CMD_RESTART: begin
        for (int i = 0; i < PAT_DEPTH; i++) align_cnt[i] = '0;
        text_pos = 0;
      end
      CMD_TEXT: shift_text(sym);
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [23:0] word);
    hit_t want;
    if (hit_q.size() == 0) begin
      report($sformatf("result start %0d count %0d with none expected",
                       word[15:0], word[22:16]));
      return;
    end
    want = hit_q.pop_front();
    if (word[15:0] !== want.start)
      report($sformatf("match_start %0d, expected %0d", word[15:0], want.start));
    if (word[22:16] !== want.mism)
      report($sformatf("mismatch_count %0d, expected %0d (start %0d)",
                       word[22:16], want.mism, want.start));
  endtask

  task automatic check_read(input logic [2:0] addr, input logic [31:0] data);
    logic [CFG_W-1:0] want;
    want = (addr[2] == REG_PATTERN_LENGTH) ? len_reg : pct_reg;
    if (data !== {25'd0, want})
      report($sformatf("register read at 0x%0h gave 0x%0h, expected 0x%0h",
                       addr, data, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAT_DEPTH; i++) align_cnt[i] = '0;
      text_pos = 0;
      len_reg  = 7'd1;
      pct_reg  = PERCENT_FULL;
      hit_q.delete();
    end else begin
      // results trail their word, so retire before taking new input
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        take_word(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[13:6]);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_PATTERN_LENGTH) len_reg = pwdata[CFG_W-1:0];
          else pct_reg = pwdata[CFG_W-1:0];
        end else begin
          check_read(paddr, prdata);
        end
      end
    end
    hits_pending_o <= hit_q.size();
    fail_count_o   <= fails;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the k-mismatch search bench: clock, reset, stimulus, sink pacing and verdict.
`timescale 1ns / 100ps

module testbench;
  import kms_pkg::*;

  // Command code the block does not use; it must be swallowed without a result.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int unsigned ITEMS_TARGET  = 1550;
  localparam int unsigned SETTLE_CYCLES = 8;      // covers the result latency
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned IDLE_LIMIT    = 2000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [5:0] pattern_index, [13:6] symbol, zero fill
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [15:0] match_start, [22:16] mismatch_count, zero fill
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned hits_pending;
  int unsigned fail_total;

  // Pacing switches, flipped per phase by the stimulus.
  bit          pace_en  = 1'b1;      // random gaps on the input side
  bit          stall_en = 1'b1;      // random back-pressure on the result side

  // Copy of what has been loaded, used only to plant near-matches in the text.
  logic [7:0]  pat_shadow [64];

  int unsigned idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  k_mismatch_string_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  kms_match_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .hits_pending_o (hits_pending),
    .fail_count_o   (fail_total)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
  endfunction

  // Watchdog: any word on either stream or a register access counts as progress.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: ready most of the time, with random stalls while stall_en is set.
  initial begin : sink_pacing
    int unsigned hold;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        hold = pick_gap();
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // All stimulus tasks start and end on a rising edge. A word is presented and held
  // until the edge where tready is seen high; the next call either drops tvalid for
  // a gap or puts the next word up, so tvalid gets one assignment per edge.
  task automatic push_word(input logic [1:0] cmd, input logic [5:0] idx,
                           input logic [7:0] sym);
    int unsigned gap;
    if (pace_en && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, sym, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_slot(input logic [5:0] idx, input logic [7:0] sym);
    pat_shadow[idx] = sym;
    push_word(CMD_LOAD, idx, sym);
  endtask

  task automatic stop_source();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Input side holds off until every predicted result has been taken.
  task automatic hold_for_results();
    stop_source();
    while (hits_pending != 0) @(posedge clk_i);
  endtask

  // A text word may still be in the pipe with no result behind it; give it time.
  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A setup phase and an access phase, then an idle phase with the bus released.
  task automatic apb_access(input bit wr, input logic addr_bit, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {addr_bit, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle; both are read back right after.
  task automatic configure(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] pct);
    settle();
    apb_access(1'b1, REG_PATTERN_LENGTH, {25'd0, len});
    apb_access(1'b1, REG_MATCH_PERCENT, {25'd0, pct});
    apb_access(1'b0, REG_PATTERN_LENGTH, '0);
    apb_access(1'b0, REG_MATCH_PERCENT, '0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_items;
    int unsigned k;
    int unsigned r;
    int unsigned plant_len;
    logic [CFG_W-1:0] len_cfg;
    logic [CFG_W-1:0] pct_cfg;
    logic [7:0] sym;
    logic [5:0] idx;

    sent = 0;
    for (int i = 0; i < 64; i++) pat_shadow[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of both registers
    apb_access(1'b0, REG_PATTERN_LENGTH, '0);
    apb_access(1'b0, REG_MATCH_PERCENT, '0);
    @(posedge clk_i);

    // Every slot is loaded before any text, so no cell ever compares against an
    // unwritten pattern byte, whatever length is set later.
    for (int i = 0; i < 64; i++) begin
      load_slot(6'(i), 8'($urandom_range(0, 255)));
      sent++;
    end

    // ---- directed part ----
    // length 4 at 100 percent: only exact matches pass (limit floor is one)
    configure(7'd4, PERCENT_FULL);
    load_slot(6'd0, 8'h00);
    load_slot(6'd1, 8'hFF);
    load_slot(6'd2, 8'hA5);
    load_slot(6'd3, 8'h5A);
    push_word(CMD_RESTART, 6'd0, 8'h00);
    // first three bytes are too short a text for any result
    push_word(CMD_TEXT, 6'd0, 8'h00);
    push_word(CMD_TEXT, 6'd63, 8'hFF);
    push_word(CMD_TEXT, 6'd0, 8'hA5);
    // exact match starting at zero
    push_word(CMD_TEXT, 6'd0, 8'h5A);
    // one wrong byte: rejected at this limit
    push_word(CMD_TEXT, 6'd0, 8'h00);
    push_word(CMD_TEXT, 6'd0, 8'hFF);
    push_word(CMD_TEXT, 6'd0, 8'h00);
    push_word(CMD_TEXT, 6'd0, 8'h5A);
    // spare command: no effect, no result
    push_word(CMD_SPARE, 6'd63, 8'hFF);
    // pattern rewrite in the middle of the text, effective from the next byte
    load_slot(6'd2, 8'h00);
    push_word(CMD_TEXT, 6'd0, 8'h00);
    push_word(CMD_TEXT, 6'd0, 8'hFF);
    push_word(CMD_TEXT, 6'd0, 8'h00);
    push_word(CMD_TEXT, 6'd0, 8'h5A);
    load_slot(6'd63, 8'hFF);
    sent += 21;

    // Pressure: sender waits out every pending result once on purpose.
    hold_for_results();

    // ---- random part ----
    // Each phase picks a setting (extremes weighted in), then streams mostly
    // planted near-copies of the pattern so alignments actually reach the limit,
    // with random bytes, mid-text loads, restarts and spare commands mixed in.
    // Phases do not restart the text by default, so a length change lands on
    // counters that are already running.
    while (sent < ITEMS_TARGET) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       len_cfg = 7'd0;
        1:       len_cfg = 7'd1;
        2:       len_cfg = 7'd64;
        3:       len_cfg = 7'($urandom_range(65, 127));
        default: len_cfg = 7'($urandom_range(2, 8));
      endcase
      r = $urandom_range(0, 5);
      case (r)
        0:       pct_cfg = 7'd0;
        1:       pct_cfg = PERCENT_FULL;
        2:       pct_cfg = 7'($urandom_range(101, 127));
        default: pct_cfg = 7'($urandom_range(40, 99));
      endcase
      configure(len_cfg, pct_cfg);
      plant_len = (len_cfg == 0) ? 1 : ((len_cfg > 64) ? 64 : len_cfg);

      // some phases run with no idling at all on either side
      pace_en  = ($urandom_range(0, 4) != 0);
      stall_en = ($urandom_range(0, 4) != 0);

      phase_items = $urandom_range(60, 130);
      k = 0;
      while (k < phase_items) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          // near-copy of the pattern, each byte corrupted with small odds
          for (int j = 0; j < plant_len; j++) begin
            sym = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : pat_shadow[j];
            push_word(CMD_TEXT, 6'($urandom_range(0, 63)), sym);
            k++;
          end
        end else if (r < 85) begin
          sym = $urandom_range(0, 1) ? pat_shadow[$urandom_range(0, plant_len - 1)]
                                     : 8'($urandom_range(0, 255));
          push_word(CMD_TEXT, 6'($urandom_range(0, 63)), sym);
          k++;
        end else if (r < 92) begin
          idx = 6'($urandom_range(0, 63));
          load_slot(idx, 8'($urandom_range(0, 255)));
          k++;
        end else if (r < 96) begin
          push_word(CMD_RESTART, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
          k++;
        end else if (r < 98) begin
          push_word(CMD_SPARE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end else begin
          hold_for_results();
        end
      end
      sent += k;
    end

    // ---- short pattern after a restart ----
    // Length 3 at zero percent lets most alignments through; the restart brings the
    // position back to zero, so the first two bytes give no result.
    pace_en  = 1'b1;
    stall_en = 1'b1;
    configure(7'd3, 7'd0);
    push_word(CMD_RESTART, 6'd0, 8'h00);
    for (int i = 0; i < 12; i++) begin
      push_word(CMD_TEXT, 6'd0, pat_shadow[i % 3]);
    end

    // ---- wind down ----
    hold_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
